@@ rtl/core/flash_sector_rmw_writer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sector-aware flash writer
// Each macro expands to a concurrent assertion clocked on clk and disabled
// while arst_n is low, or to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FLASH_SECTOR_RMW_WRITER_DEFINES_SVH
`define FLASH_SECTOR_RMW_WRITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSRW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("flash writer check failed");
`define FSRW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flash writer sequencing check failed");
`else
`define FSRW_ASSERT_IMP(label, ante, cons)
`define FSRW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/fsrw_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash writer package
// Action and status codes, field widths and fixed constants of the writer.
// ----------------------------------------------------------------------------
package fsrw_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W  = 9;
	localparam int SIDX_W = 8;
	localparam int WORD_W = 16;
	localparam int KB_W   = 7;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_COMMIT = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ADDR  = 2'd1;
	localparam logic [1:0] STAT_COUNT = 2'd2;

	localparam logic [ADDR_W-1:0] FLASH_BASE   = 32'h0800_0000;
	localparam logic [WORD_W-1:0] ERASED_WORD  = 16'hFFFF;
	localparam logic [CNT_W-1:0]  MAX_READ_RUN = 9'd64;
	localparam logic [KB_W-1:0]   SIZE_KB_RST  = 7'd64;

endpackage

@@ rtl/core/flash_sector_rmw_writer.sv @@
// ----------------------------------------------------------------------------
// Sector-aware flash writer
// Staging buffer, commit sequencer with sector blank check, and read runs
// over a modelled flash array.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_axis channel (action in tuser, other fields in
// tdata) and results leave on m_axis, one beat per result, tlast on the final
// one. The flash size register is written on the cfg channel, which is always
// ready; write it only while the block is idle.
// After reset the block sweeps the flash array to 0xFFFF, one halfword per
// cycle, and accepts no item until the sweep ends. One item is handled at a
// time. A commit works through sector pieces, the shared address adder and
// the flash array doing one access per cycle for the blank check and again
// for programming. A read run does one flash read and then one output load
// per halfword. The result register frees the input side: the next item is
// accepted while the final result of the previous one still waits. When the
// receiver stalls, the sequencer holds before loading its next result.
// ----------------------------------------------------------------------------
`include "flash_sector_rmw_writer_defines.svh"

module flash_sector_rmw_writer #(
	parameter int SECTOR_BYTES = 2048,
	parameter int FLASH_WORDS  = 32768,
	parameter int STAGE_WORDS  = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// address[31:0], word_count[40:32], stage_index[48:41], data_word[64:49]
	input  logic [71:0]                s_axis_tdata,
	// action[1:0]
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status[1:0], pages_erased[3:2], words_programmed[15:4], read_data[31:16]
	output logic [31:0]                m_axis_tdata,
	output logic                       m_axis_tlast,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fsrw_pkg::KB_W-1:0]  cfg_flash_size_kb
);

	import fsrw_pkg::*;

	localparam int SEC_WORDS = SECTOR_BYTES / 2;
	localparam int FAW       = $clog2(FLASH_WORDS);
	localparam int SAW       = $clog2(STAGE_WORDS);
	localparam int SEC_AW    = $clog2(SEC_WORDS);
	localparam int WW        = (FAW > SEC_AW) ? FAW : SEC_AW;
	localparam int PW        = (SEC_AW + 1 > CNT_W) ? SEC_AW + 1 : CNT_W;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_CHECK    = 4'd2;
	localparam logic [3:0] S_PIECE    = 4'd3;
	localparam logic [3:0] S_SCAN     = 4'd4;
	localparam logic [3:0] S_PROG     = 4'd5;
	localparam logic [3:0] S_READ     = 4'd6;
	localparam logic [3:0] S_READ_OUT = 4'd7;
	localparam logic [3:0] S_RESULT   = 4'd8;

	logic [3:0]        state_q;
	logic [FAW-1:0]    clr_q;
	logic [KB_W-1:0]   size_kb_q;
	logic              pend_s1;
	logic [FAW-1:0]    wa_s1;
	logic [CNT_W-1:0]  i_q;

	logic [1:0]        act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIDX_W-1:0] sidx_q;
	logic [WORD_W-1:0] data_q;

	logic [WW-1:0]     w_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  src_q;
	logic              dirty_q;
	logic [1:0]        erased_q;
	logic [11:0]       prog_q;
	logic [1:0]        res_status_q;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic              m_tlast_q;

	logic              in_accept;
	logic              out_free;
	logic              out_load;
	logic [31:0]       out_data_d;
	logic              out_last_d;

	logic              span_bad;
	logic [FAW-1:0]    span_word;
	logic              commit_big;
	logic              read_big;
	logic              sidx_ok;

	logic [WW-1:0]     ptr_sum;
	logic              issue;
	logic [PW-1:0]     room;
	logic [CNT_W-1:0]  n_next;
	logic [CNT_W-1:0]  rem_next;
	logic [12:0]       prog_sum;
	logic [11:0]       prog_sat;
	logic              rd_last;

	logic              flash_we;
	logic [FAW-1:0]    flash_wa;
	logic [WORD_W-1:0] flash_wd;
	logic              flash_re;
	logic [WORD_W-1:0] flash_rdata;
	logic              stage_we;
	logic              stage_re;
	logic [SAW-1:0]    stage_ra;
	logic [WORD_W-1:0] stage_rdata;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

	fsrw_span_chk #(
		.FLASH_WORDS(FLASH_WORDS)
	) u_span_chk (
		.addr   (addr_q),
		.count  (cnt_q),
		.size_kb(size_kb_q),
		.bad    (span_bad),
		.word   (span_word)
	);

	assign commit_big = 32'(cnt_q) > 32'(STAGE_WORDS);
	assign read_big   = cnt_q > MAX_READ_RUN;
	assign sidx_ok    = 32'(sidx_q) < 32'(STAGE_WORDS);

	assign ptr_sum  = w_q + WW'(i_q);
	assign issue    = i_q < n_q;
	assign room     = PW'(SEC_WORDS) - PW'(w_q[SEC_AW-1:0]);
	assign n_next   = (room < PW'(rem_q)) ? CNT_W'(room) : rem_q;
	assign rem_next = rem_q - n_q;
	assign prog_sum = {1'b0, prog_q} + (dirty_q ? 13'(SEC_WORDS) : 13'(n_q));
	assign prog_sat = prog_sum[12] ? 12'hFFF : prog_sum[11:0];
	assign rd_last  = (i_q + CNT_W'(1)) == cnt_q;

	assign flash_re = ((state_q == S_SCAN) && issue) || (state_q == S_READ);
	assign flash_we = (state_q == S_CLEAR) || ((state_q == S_PROG) && pend_s1);
	assign flash_wa = (state_q == S_CLEAR) ? clr_q : wa_s1;
	assign flash_wd = (state_q == S_CLEAR) ? ERASED_WORD : stage_rdata;

	assign stage_we = (state_q == S_CHECK) && (act_q == ACT_LOAD) && sidx_ok;
	assign stage_re = (state_q == S_PROG) && issue;
	assign stage_ra = SAW'(src_q + i_q);

	fsrw_ram #(
		.DEPTH(FLASH_WORDS),
		.WIDTH(WORD_W)
	) u_flash (
		.clk  (clk),
		.we   (flash_we),
		.waddr(flash_wa),
		.wdata(flash_wd),
		.re   (flash_re),
		.raddr(FAW'(ptr_sum)),
		.rdata(flash_rdata)
	);

	fsrw_ram #(
		.DEPTH(STAGE_WORDS),
		.WIDTH(WORD_W)
	) u_stage (
		.clk  (clk),
		.we   (stage_we),
		.waddr(SAW'(sidx_q)),
		.wdata(data_q),
		.re   (stage_re),
		.raddr(stage_ra),
		.rdata(stage_rdata)
	);

	assign out_free = !m_tvalid_q || m_axis_tready;
	assign out_load = out_free && ((state_q == S_RESULT) || (state_q == S_READ_OUT));

	always_comb begin
		if (state_q == S_READ_OUT) begin
			out_data_d = {flash_rdata, 12'b0, 2'b0, STAT_OK};
			out_last_d = rd_last;
		end else begin
			out_data_d = {16'b0, prog_q, erased_q, res_status_q};
			out_last_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			size_kb_q  <= SIZE_KB_RST;
			pend_s1    <= 1'b0;
			i_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_kb_q <= cfg_flash_size_kb;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			pend_s1 <= ((state_q == S_SCAN) || (state_q == S_PROG)) && issue;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FAW'(1);
					if (clr_q == FAW'(FLASH_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					i_q <= '0;
					if (in_accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					unique case (act_q)
						ACT_LOAD: state_q <= S_RESULT;
						ACT_COMMIT: begin
							if (commit_big || span_bad || (cnt_q == '0)) begin
								state_q <= S_RESULT;
							end else begin
								state_q <= S_PIECE;
							end
						end
						ACT_READ: begin
							if (read_big || span_bad || (cnt_q == '0)) begin
								state_q <= S_RESULT;
							end else begin
								state_q <= S_READ;
							end
						end
						ACT_NONE: state_q <= S_IDLE;
					endcase
				end
				S_PIECE: begin
					i_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						i_q <= i_q + CNT_W'(1);
					end else if (!pend_s1) begin
						i_q     <= '0;
						state_q <= S_PROG;
					end
				end
				S_PROG: begin
					if (issue) begin
						i_q <= i_q + CNT_W'(1);
					end else if (!pend_s1) begin
						state_q <= (rem_next == '0) ? S_RESULT : S_PIECE;
					end
				end
				S_READ: state_q <= S_READ_OUT;
				S_READ_OUT: begin
					if (out_load) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= rd_last ? S_IDLE : S_READ;
					end
				end
				S_RESULT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q  <= s_axis_tuser;
			addr_q <= s_axis_tdata[31:0];
			cnt_q  <= s_axis_tdata[40:32];
			sidx_q <= s_axis_tdata[48:41];
			data_q <= s_axis_tdata[64:49];
		end
		if (out_load) begin
			m_tdata_q <= out_data_d;
			m_tlast_q <= out_last_d;
		end
		wa_s1 <= FAW'(ptr_sum);
		if (state_q == S_CHECK) begin
			erased_q <= '0;
			prog_q   <= '0;
			w_q      <= WW'(span_word);
			rem_q    <= cnt_q;
			src_q    <= '0;
			if ((act_q == ACT_COMMIT) && commit_big) begin
				res_status_q <= STAT_COUNT;
			end else if ((act_q == ACT_READ) && read_big) begin
				res_status_q <= STAT_COUNT;
			end else if ((act_q != ACT_LOAD) && span_bad) begin
				res_status_q <= STAT_ADDR;
			end else begin
				res_status_q <= STAT_OK;
			end
		end
		if (state_q == S_PIECE) begin
			n_q     <= n_next;
			dirty_q <= 1'b0;
		end
		if ((state_q == S_SCAN) && pend_s1 && (flash_rdata != ERASED_WORD)) begin
			dirty_q <= 1'b1;
		end
		if ((state_q == S_SCAN) && !issue && !pend_s1) begin
			prog_q <= prog_sat;
			if (dirty_q && (erased_q != 2'd3)) begin
				erased_q <= erased_q + 2'd1;
			end
		end
		if ((state_q == S_PROG) && !issue && !pend_s1) begin
			w_q   <= w_q + WW'(n_q);
			src_q <= src_q + n_q;
			rem_q <= rem_next;
		end
	end

	`FSRW_ASSERT_IMP(a_clear_blocks_input, state_q == S_CLEAR, !s_axis_tready)
	`FSRW_ASSERT_IMP(a_flash_write_phase, flash_we, (state_q == S_CLEAR) || (state_q == S_PROG))
	`FSRW_ASSERT_IMP(a_piece_has_work, state_q == S_PIECE, rem_q != '0)
	`FSRW_ASSERT_NEXT(a_accept_to_check, in_accept, state_q == S_CHECK)

endmodule

@@ rtl/core/fsrw_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
module fsrw_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/fsrw_span_chk.sv @@
// ----------------------------------------------------------------------------
// Span range check
// Checks that a halfword span lies at or above the flash base and inside the
// usable size, and gives the halfword index of its first word.
// ----------------------------------------------------------------------------
module fsrw_span_chk #(
	parameter int FLASH_WORDS = 32768
) (
	input  logic [fsrw_pkg::ADDR_W-1:0]     addr,
	input  logic [fsrw_pkg::CNT_W-1:0]      count,
	input  logic [fsrw_pkg::KB_W-1:0]       size_kb,
	output logic                            bad,
	output logic [$clog2(FLASH_WORDS)-1:0]  word
);

	import fsrw_pkg::*;

	localparam int FAW = $clog2(FLASH_WORDS);
	localparam logic [33:0] FLASH_LIM = 34'(FLASH_WORDS) * 34'd2;

	logic [33:0]       kb_lim;
	logic [33:0]       lim;
	logic [ADDR_W-1:0] diff;
	logic [33:0]       off;
	logic [33:0]       end_off;

	assign kb_lim  = {17'b0, size_kb, 10'b0};
	assign lim     = (kb_lim < FLASH_LIM) ? kb_lim : FLASH_LIM;
	assign diff    = addr - FLASH_BASE;
	assign off     = {2'b0, diff[ADDR_W-1:1], 1'b0};
	assign end_off = off + {24'b0, count, 1'b0};
	assign bad     = (addr < FLASH_BASE) || (off >= lim) || (end_off > lim);
	assign word    = off[FAW:1];

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sector-aware flash writer
// Drives load, commit, read and no-op beats on the input stream and checks
// every result beat against a local model of the flash array and staging
// buffer or the expected beat of a directed case. A short table of directed
// cases comes first, then phases of random item sequences under several flash
// size settings, with random idling on both streams except in the last phase.
// ----------------------------------------------------------------------------
module tb;

	import fsrw_pkg::*;

	localparam int SECTOR_WORDS = 1024;
	localparam int FLASH_WORDS  = 32768;
	localparam int SLOTS        = 256;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 39;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 120000;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  pages_erased;
		logic [11:0] words_programmed;
		logic [15:0] read_data;
		logic        last;
	} result_beat_t;

	typedef struct {
		logic [1:0]   act;
		logic [31:0]  addr;
		logic [8:0]   cnt;
		logic [7:0]   sidx;
		logic [15:0]  dw;
		bit           typed;
		result_beat_t beat;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = ACT_LOAD;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [KB_W-1:0] cfg_flash_size_kb = SIZE_KB_RST;

	logic [15:0]     flash_mem [FLASH_WORDS];
	logic [15:0]     stage_mem [SLOTS];
	bit              stage_written [SLOTS];
	logic [KB_W-1:0] size_kb = SIZE_KB_RST;
	result_beat_t    expected_beats [$];

	int n_err = 0;
	int items_sent = 0;
	int tx_idle_pct = 20;
	int rx_idle_pct = 20;
	int rx_hold = 0;
	int stall_cycles = 0;

	stim_row_t stim_table [25] = '{
		'{ACT_READ,   FLASH_BASE,          9'd1,   8'd0,   16'h0000, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, ERASED_WORD, 1'b1}},
		'{ACT_LOAD,   32'h0,               9'd0,   8'd0,   16'h0000, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_LOAD,   32'h0,               9'd0,   8'd1,   16'hFFFF, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_LOAD,   32'h0,               9'd0,   8'd2,   16'hA5C3, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_LOAD,   32'h0,               9'd0,   8'd3,   16'h5A3C, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_LOAD,   32'h0,               9'd0,   8'd255, 16'h1234, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, FLASH_BASE,          9'd0,   8'd0,   16'h0000, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, FLASH_BASE,          9'd257, 8'd0,   16'h0000, 1'b1,
			'{STAT_COUNT, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, 32'h0,               9'd511, 8'd0,   16'h0000, 1'b1,
			'{STAT_COUNT, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, 32'h07FF_FFFE,       9'd256, 8'd0,   16'h0000, 1'b1,
			'{STAT_ADDR, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, 32'hFFFF_FFFF,       9'd4,   8'd0,   16'h0000, 1'b1,
			'{STAT_ADDR, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, FLASH_BASE + 32'h10000, 9'd4, 8'd0,  16'h0000, 1'b1,
			'{STAT_ADDR, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, FLASH_BASE + 32'hFFFC, 9'd2, 8'd0,   16'h0000, 1'b0, '0},
		'{ACT_COMMIT, FLASH_BASE + 32'hFFFE, 9'd2, 8'd0,   16'h0000, 1'b1,
			'{STAT_ADDR, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_COMMIT, FLASH_BASE + 32'h7FF,  9'd4, 8'd0,   16'h0000, 1'b0, '0},
		'{ACT_COMMIT, FLASH_BASE + 32'h7FE,  9'd4, 8'd0,   16'h0000, 1'b0, '0},
		'{ACT_READ,   FLASH_BASE + 32'h7FE,  9'd4, 8'd0,   16'h0000, 1'b0, '0},
		'{ACT_READ,   FLASH_BASE,          9'd65,  8'd0,   16'h0000, 1'b1,
			'{STAT_COUNT, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_READ,   FLASH_BASE + 32'hFF80, 9'd64, 8'd0,  16'h0000, 1'b0, '0},
		'{ACT_READ,   FLASH_BASE,          9'd0,   8'd0,   16'h0000, 1'b1,
			'{STAT_OK, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_READ,   32'h0,               9'd1,   8'd0,   16'h0000, 1'b1,
			'{STAT_ADDR, 2'd0, 12'd0, 16'h0, 1'b1}},
		'{ACT_NONE,   FLASH_BASE,          9'd4,   8'd7,   16'hBEEF, 1'b0, '0},
		'{ACT_COMMIT, FLASH_BASE + 32'h4,  9'd1,   8'd0,   16'h0000, 1'b0, '0},
		'{ACT_COMMIT, FLASH_BASE + 32'h4,  9'd1,   8'd0,   16'h0000, 1'b0, '0},
		'{ACT_READ,   FLASH_BASE + 32'h4,  9'd1,   8'd0,   16'h0000, 1'b0, '0}
	};

	flash_sector_rmw_writer u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.s_axis_tuser      (s_axis_tuser),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.m_axis_tlast      (m_axis_tlast),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_flash_size_kb (cfg_flash_size_kb)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned byte_limit();
		longint unsigned lim;
		lim = longint'(size_kb) * 1024;
		if (lim > 2 * FLASH_WORDS)
			lim = 2 * FLASH_WORDS;
		return lim;
	endfunction

	function automatic bit span_ok(input logic [31:0] addr, input logic [8:0] cnt,
			output int word);
		longint unsigned off;
		longint unsigned lim;
		word = 0;
		lim = byte_limit();
		if (addr < FLASH_BASE)
			return 1'b0;
		off = {32'd0, addr - FLASH_BASE} & ~64'd1;
		if (off >= lim || off + 2 * cnt > lim)
			return 1'b0;
		word = int'(off >> 1);
		return 1'b1;
	endfunction

	function automatic int stage_prefix();
		int p;
		p = 0;
		while (p < SLOTS && stage_written[p])
			p++;
		return p;
	endfunction

	function automatic void predict_flash_item(input logic [1:0] act, input logic [31:0] addr,
			input logic [8:0] cnt, input logic [7:0] sidx, input logic [15:0] dw);
		int w, src, remaining, so, n, erased, prog;
		bit clean;
		result_beat_t b;
		b = '0;
		b.last = 1'b1;
		case (act)
			ACT_LOAD: begin
				stage_mem[sidx] = dw;
				stage_written[sidx] = 1'b1;
				expected_beats.push_back(b);
			end
			ACT_COMMIT: begin
				if (cnt > SLOTS) begin
					b.status = STAT_COUNT;
				end else if (!span_ok(addr, cnt, w)) begin
					b.status = STAT_ADDR;
				end else begin
					src = 0;
					remaining = int'(cnt);
					erased = 0;
					prog = 0;
					while (remaining > 0) begin
						so = w % SECTOR_WORDS;
						n = SECTOR_WORDS - so;
						if (n > remaining)
							n = remaining;
						clean = 1'b1;
						for (int i = 0; i < n; i++)
							if (flash_mem[w + i] != ERASED_WORD)
								clean = 1'b0;
						for (int i = 0; i < n; i++)
							flash_mem[w + i] = stage_mem[src + i];
						if (clean) begin
							prog += n;
						end else begin
							erased++;
							prog += SECTOR_WORDS;
						end
						w += n;
						src += n;
						remaining -= n;
					end
					b.pages_erased = (erased > 3) ? 2'd3 : 2'(erased);
					b.words_programmed = (prog > 4095) ? 12'hFFF : 12'(prog);
				end
				expected_beats.push_back(b);
			end
			ACT_READ: begin
				if (cnt > MAX_READ_RUN) begin
					b.status = STAT_COUNT;
					expected_beats.push_back(b);
				end else if (!span_ok(addr, cnt, w)) begin
					b.status = STAT_ADDR;
					expected_beats.push_back(b);
				end else if (cnt == 0) begin
					expected_beats.push_back(b);
				end else begin
					for (int i = 0; i < int'(cnt); i++) begin
						b.read_data = flash_mem[w + i];
						b.last = (i == int'(cnt) - 1);
						expected_beats.push_back(b);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_err++;
		end
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [31:0] addr,
			input logic [8:0] cnt, input logic [7:0] sidx, input logic [15:0] dw,
			input bit typed, input result_beat_t typed_beat);
		int gap;
		int n0;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {7'd0, dw, sidx, cnt, addr};
		do
			@(posedge clk);
		while (!s_axis_tready);
		n0 = expected_beats.size();
		predict_flash_item(act, addr, cnt, sidx, dw);
		if (typed) begin
			while (expected_beats.size() > n0)
				void'(expected_beats.pop_back());
			expected_beats.push_back(typed_beat);
		end
		items_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size_kb(input logic [KB_W-1:0] kb);
		cfg_valid <= 1'b1;
		cfg_flash_size_kb <= kb;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_kb = kb;
	endtask

	always @(posedge clk) begin : result_side
		result_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with none expected: tdata 0x%0h", m_axis_tdata);
				n_err++;
			end else begin
				want = expected_beats.pop_front();
				compare_field("status", want.status, m_axis_tdata[1:0]);
				compare_field("pages_erased", want.pages_erased, m_axis_tdata[3:2]);
				compare_field("words_programmed", want.words_programmed, m_axis_tdata[15:4]);
				compare_field("read_data", want.read_data, m_axis_tdata[31:16]);
				compare_field("last", want.last, m_axis_tlast);
			end
		end
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
			rx_hold <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int p, cnt, w, lw, start, len, last_w, phase_end;
		logic [1:0] act;
		logic [31:0] a;
		logic [KB_W-1:0] kb;
		foreach (flash_mem[i])
			flash_mem[i] = ERASED_WORD;
		foreach (stage_mem[i]) begin
			stage_mem[i] = '0;
			stage_written[i] = 1'b0;
		end
		last_w = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[r])
			send_item(stim_table[r].act, stim_table[r].addr, stim_table[r].cnt,
				stim_table[r].sidx, stim_table[r].dw, stim_table[r].typed, stim_table[r].beat);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: kb = 7'd1;
				1: kb = 7'd0;
				2: kb = 7'd127;
				3: kb = 7'd17;
				4: kb = 7'($urandom_range(2, 63));
				default: kb = SIZE_KB_RST;
			endcase
			write_size_kb(kb);
			tx_idle_pct = (phase == PHASES - 1) ? 0 : 15 * int'($urandom_range(0, 2));
			rx_idle_pct = (phase == PHASES - 1) ? 0 : 15 * int'($urandom_range(0, 2));
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 12) begin
					act = 2'($urandom_range(0, 3));
					a = $urandom_range(0, 1) ? $urandom : FLASH_BASE + $urandom_range(0, 70000);
					cnt = $urandom_range(0, 511);
					p = stage_prefix();
					if (act == ACT_COMMIT && cnt <= SLOTS && span_ok(a, 9'(cnt), w) && cnt > p)
						cnt = p;
					send_item(act, a, 9'(cnt), 8'($urandom_range(0, 255)), 16'($urandom),
						1'b0, '0);
				end else begin
					len = $urandom_range(1, 10);
					p = stage_prefix();
					start = (p >= SLOTS) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, p);
					for (int j = 0; j < len && start + j < SLOTS; j++)
						send_item(ACT_LOAD, $urandom, 9'($urandom_range(0, 511)), 8'(start + j),
							($urandom_range(0, 5) == 0) ? ERASED_WORD : 16'($urandom),
							1'b0, '0);

					p = stage_prefix();
					if (p == 0)
						cnt = 0;
					else if ($urandom_range(0, 7) == 0)
						cnt = $urandom_range(0, p);
					else
						cnt = $urandom_range(1, (p < 24) ? p : 24);
					lw = int'(byte_limit() / 2);
					case ($urandom_range(0, 3))
						0: w = $urandom_range(0, 63);
						1: w = SECTOR_WORDS - int'($urandom_range(1, 48));
						2: w = lw - int'($urandom_range(1, 64));
						default: w = (lw > 0) ? int'($urandom_range(0, lw - 1)) : 0;
					endcase
					if (w < 0)
						w = 0;
					if (w + cnt > lw && lw >= cnt && $urandom_range(0, 15) != 0)
						w = lw - cnt;
					last_w = w;
					a = FLASH_BASE + 32'(2 * w) + 32'($urandom_range(0, 1));
					send_item(ACT_COMMIT, a, 9'(cnt), 8'($urandom), 16'($urandom), 1'b0, '0);

					if ($urandom_range(0, 9) < 6) begin
						cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
							: $urandom_range(1, 12);
						w = last_w + int'($urandom_range(0, 3));
						if (w + cnt > lw && lw >= cnt && $urandom_range(0, 15) != 0)
							w = lw - cnt;
						a = FLASH_BASE + 32'(2 * w) + 32'($urandom_range(0, 1));
						send_item(ACT_READ, a, 9'(cnt), 8'($urandom), 16'($urandom), 1'b0, '0);
					end
				end
			end
		end

		settle();
		if (n_err == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
